// ----- sv/arp_responder_with_cache_defines.svh -----
// ----------------------------------------------------------------------------
// ARP responder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARP_RESPONDER_WITH_CACHE_DEFINES_SVH
`define ARP_RESPONDER_WITH_CACHE_DEFINES_SVH

// Same-cycle implication.
`define ARPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg
// Field widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

  localparam int unsigned IP_W   = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned OPC_W  = 16;
  localparam int unsigned CFG_IW = 2;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_OWN_IP   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_OWN_MAC  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_NET_MASK = 2'd2;

  localparam logic [IP_W-1:0] NET_MASK_RST = 32'hFFFF_FF00;

  // Item kinds
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // ARP opcodes as on the wire
  localparam logic [OPC_W-1:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [OPC_W-1:0] ARP_OP_REPLY   = 16'd2;

  typedef struct packed {
    logic accept;       // latch input transaction, arm the scan
    logic scan_run;     // step the cache scan
    logic write;        // write the cache entry
    logic load_result;  // move the result into the output register
  } arpc_cmd_t;

  typedef struct packed {
    logic need_scan;    // item at the input needs a cache scan
    logic scan_done;    // scan reached a hit or the last entry
    logic upd_item;     // latched item updates the cache
  } arpc_sts_t;

endpackage

`default_nettype wire

// ----- sv/arpc_ram.sv -----
// ----------------------------------------------------------------------------
// arpc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- sv/arpc_datapath.sv -----
// ----------------------------------------------------------------------------
// arpc_datapath
// Configuration registers, item decode, cache scan, cache write, result regs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "arp_responder_with_cache_defines.svh"

module arpc_datapath #(
  parameter int unsigned CACHE_DEPTH = 16,
  parameter int unsigned HOST_BITS   = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [arpc_pkg::CFG_IW-1:0]  cfg_index_i,
  input  wire logic [arpc_pkg::MAC_W-1:0]   cfg_data_i,
  input  wire logic                         operation_i,
  input  wire logic [arpc_pkg::OPC_W-1:0]   arp_opcode_i,
  input  wire logic [arpc_pkg::MAC_W-1:0]   sender_mac_i,
  input  wire logic [arpc_pkg::IP_W-1:0]    sender_ip_i,
  input  wire logic [arpc_pkg::IP_W-1:0]    target_ip_i,
  input  wire logic [arpc_pkg::IP_W-1:0]    query_ip_i,
  input  wire arpc_pkg::arpc_cmd_t          cmd_i,
  output arpc_pkg::arpc_sts_t               sts_o,
  output logic                              send_reply_o,
  output logic      [arpc_pkg::MAC_W-1:0]   reply_target_mac_o,
  output logic      [arpc_pkg::IP_W-1:0]    reply_target_ip_o,
  output logic                              found_o,
  output logic      [arpc_pkg::MAC_W-1:0]   found_mac_o
);

  localparam int unsigned IW = $clog2(CACHE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_DEPTH - 1);

  // Configuration registers
  logic [arpc_pkg::IP_W-1:0]  own_ip_q, net_mask_q;
  logic [arpc_pkg::MAC_W-1:0] own_mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q   <= '0;
      own_mac_q  <= '0;
      net_mask_q <= arpc_pkg::NET_MASK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        arpc_pkg::CFG_OWN_IP:   own_ip_q   <= cfg_data_i[arpc_pkg::IP_W-1:0];
        arpc_pkg::CFG_OWN_MAC:  own_mac_q  <= cfg_data_i;
        arpc_pkg::CFG_NET_MASK: net_mask_q <= cfg_data_i[arpc_pkg::IP_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode of the item at the input
  logic                 is_lookup, tgt_match, in_subnet, is_req, is_upd;
  logic [arpc_pkg::IP_W-1:0] key_ip, key_masked;

  always_comb begin
    is_lookup  = (operation_i == arpc_pkg::OP_LOOKUP);
    tgt_match  = (target_ip_i == own_ip_q);
    in_subnet  = ((sender_ip_i & net_mask_q) == (own_ip_q & net_mask_q));
    is_req     = !is_lookup && tgt_match && (arp_opcode_i == arpc_pkg::ARP_OP_REQUEST);
    is_upd     = !is_lookup && tgt_match && in_subnet &&
                 (arp_opcode_i == arpc_pkg::ARP_OP_REPLY);
    key_ip     = is_lookup ? query_ip_i : sender_ip_i;
    key_masked = key_ip & ~net_mask_q;
  end

  // Latched item
  logic                       lookup_q, req_q, upd_q;
  logic [HOST_BITS-1:0]       key_q;
  logic [arpc_pkg::MAC_W-1:0] smac_q;
  logic [arpc_pkg::IP_W-1:0]  sip_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lookup_q <= is_lookup;
      req_q    <= is_req;
      upd_q    <= is_upd;
      key_q    <= key_masked[HOST_BITS-1:0];
      smac_q   <= sender_mac_i;
      sip_q    <= sender_ip_i;
    end
  end

  // Scan control: issue addresses 0 upward, compare in the following cycle
  logic                       issue_q, cmp_vld_q, hit_q;
  logic [IW-1:0]              scan_q, cmp_idx_q, hit_idx_q, wp_q;
  logic [CACHE_DEPTH-1:0]     valid_q;
  logic [HOST_BITS-1:0]       host_rd, entry_host;
  logic [arpc_pkg::MAC_W-1:0] mac_rd, entry_mac, hit_mac_q;
  logic                       entry_vld, match, rd_en;
  logic [IW-1:0]              wr_addr;

  assign rd_en      = cmd_i.scan_run && issue_q;
  assign entry_vld  = valid_q[cmp_idx_q];
  assign entry_host = entry_vld ? host_rd : '0;
  assign entry_mac  = entry_vld ? mac_rd : '0;
  assign match      = cmp_vld_q && (entry_host == key_q);
  assign wr_addr    = hit_q ? hit_idx_q : wp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q   <= 1'b0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      scan_q    <= '0;
      cmp_idx_q <= '0;
      hit_idx_q <= '0;
    end else if (cmd_i.accept) begin
      issue_q   <= 1'b1;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      scan_q    <= '0;
    end else begin
      cmp_vld_q <= rd_en;
      if (rd_en) begin
        cmp_idx_q <= scan_q;
        if (scan_q == LAST_IDX) begin
          issue_q <= 1'b0;
        end else begin
          scan_q <= scan_q + IW'(1);
        end
      end
      if (cmd_i.scan_run && match) begin
        hit_q     <= 1'b1;
        hit_idx_q <= cmp_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_run && match) begin
      hit_mac_q <= entry_mac;
    end
  end

  // Valid bits and round-robin write pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      wp_q    <= '0;
    end else if (cmd_i.write) begin
      valid_q[wr_addr] <= 1'b1;
      if (!hit_q) begin
        wp_q <= (wp_q == LAST_IDX) ? '0 : wp_q + IW'(1);
      end
    end
  end

  arpc_ram #(
    .WIDTH (HOST_BITS),
    .DEPTH (CACHE_DEPTH)
  ) u_host_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.write),
    .wr_addr_i (wr_addr),
    .wr_data_i (key_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (scan_q),
    .rd_data_o (host_rd)
  );

  arpc_ram #(
    .WIDTH (arpc_pkg::MAC_W),
    .DEPTH (CACHE_DEPTH)
  ) u_mac_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.write),
    .wr_addr_i (wr_addr),
    .wr_data_i (smac_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (scan_q),
    .rd_data_o (mac_rd)
  );

  assign sts_o.need_scan = is_lookup || is_upd;
  assign sts_o.scan_done = cmp_vld_q && (match || (cmp_idx_q == LAST_IDX));
  assign sts_o.upd_item  = upd_q;

  // Result register
  logic                       send_reply_q, found_q;
  logic [arpc_pkg::MAC_W-1:0] rmac_q, fmac_q;
  logic [arpc_pkg::IP_W-1:0]  rip_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      send_reply_q <= req_q;
      rmac_q       <= req_q ? smac_q : '0;
      rip_q        <= req_q ? sip_q : '0;
      found_q      <= lookup_q && hit_q;
      fmac_q       <= (lookup_q && hit_q) ? hit_mac_q : '0;
    end
  end

  assign send_reply_o       = send_reply_q;
  assign reply_target_mac_o = rmac_q;
  assign reply_target_ip_o  = rip_q;
  assign found_o            = found_q;
  assign found_mac_o        = fmac_q;

  `ARPC_ASSERT_NEXT(a_insert_sets_valid, cmd_i.write && !hit_q, valid_q[$past(wp_q)], "not valid")
  `ARPC_ASSERT_NEXT(a_result_exclusive, cmd_i.load_result, !(send_reply_q && found_q), "both set")
  `ARPC_ASSERT_NOW(a_write_needs_upd, cmd_i.write, upd_q, "cache write without update item")

endmodule

`default_nettype wire

// ----- sv/arpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer for accept, cache scan, cache write and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "arp_responder_with_cache_defines.svh"

module arpc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire arpc_pkg::arpc_sts_t sts_i,
  output arpc_pkg::arpc_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.need_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          state_d = sts_i.upd_item ? S_UPDATE : S_DONE;
        end
      end
      S_UPDATE: begin
        cmd_o.write = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ARPC_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != S_IDLE, "accept did not leave idle")
  `ARPC_ASSERT_NEXT(a_update_one_cycle, state_q == S_UPDATE, state_q == S_DONE, "cache write not single cycle")
  `ARPC_ASSERT_NOW(a_load_when_free, cmd_o.load_result, !out_valid_q || out_ready_i, "result overwrote pending output")

endmodule

`default_nettype wire

// ----- sv/arp_responder_with_cache.sv -----
// ----------------------------------------------------------------------------
// arp_responder_with_cache
// ARP request responder with a round-robin MAC cache keyed by host part.
// Input channel (in_valid_i/in_ready_o) carries one transaction: either a
// received ARP header (operation_i = 0) or a MAC lookup by IP (1). Output
// channel (out_valid_o/out_ready_i) returns exactly one result per input
// transaction, in order. Config channel (cfg_valid_i/cfg_ready_o) writes
// own_ip (index 0), own_mac (1) and net_mask (2); it is always ready. Write
// it only while the block is idle.
// Steps: headers that need no cache access go from accept straight to the
// result. Lookups and cache-updating replies scan one entry per cycle through
// the registered RAM read port: accept, scan until a hit or the last entry, a
// write step for an update, then the result.
// One transaction is in flight at a time; the next is accepted once the result
// sits in the output register.
// Reset restores config defaults, clears the cache (per-entry valid bits)
// and the write pointer, and drops any pending result. A stalled receiver
// holds the result; a finished item waits and the input stays closed.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_responder_with_cache #(
  parameter int unsigned CACHE_DEPTH = 16,
  parameter int unsigned HOST_BITS   = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write channel
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [arpc_pkg::CFG_IW-1:0] cfg_index_i,
  input  wire logic [arpc_pkg::MAC_W-1:0]  cfg_data_i,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        operation_i,
  input  wire logic [arpc_pkg::OPC_W-1:0]  arp_opcode_i,
  input  wire logic [arpc_pkg::MAC_W-1:0]  sender_mac_i,
  input  wire logic [arpc_pkg::IP_W-1:0]   sender_ip_i,
  input  wire logic [arpc_pkg::IP_W-1:0]   target_ip_i,
  input  wire logic [arpc_pkg::IP_W-1:0]   query_ip_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             send_reply_o,
  output logic      [arpc_pkg::MAC_W-1:0]  reply_target_mac_o,
  output logic      [arpc_pkg::IP_W-1:0]   reply_target_ip_o,
  output logic                             found_o,
  output logic      [arpc_pkg::MAC_W-1:0]  found_mac_o
);

  arpc_pkg::arpc_cmd_t cmd;
  arpc_pkg::arpc_sts_t sts;

  // Config registers live in the datapath and take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  arpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  arpc_datapath #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .HOST_BITS   (HOST_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .operation_i        (operation_i),
    .arp_opcode_i       (arp_opcode_i),
    .sender_mac_i       (sender_mac_i),
    .sender_ip_i        (sender_ip_i),
    .target_ip_i        (target_ip_i),
    .query_ip_i         (query_ip_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .send_reply_o       (send_reply_o),
    .reply_target_mac_o (reply_target_mac_o),
    .reply_target_ip_o  (reply_target_ip_o),
    .found_o            (found_o),
    .found_mac_o        (found_mac_o)
  );

endmodule

`default_nettype wire

// ----- test/tb_arp_responder_with_cache.sv -----
// ----------------------------------------------------------------------------
// tb_arp_responder_with_cache
// Self-checking bench for the ARP responder: an in-bench model of the reply
// decision and the round-robin MAC cache predicts one result per transaction,
// and every result taken from the output channel is compared field by field.
// ----------------------------------------------------------------------------
module tb_arp_responder_with_cache;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CACHE_DEPTH = 16;
  localparam int HOST_BITS   = 8;
  localparam int POOL_SIZE   = 24;   // more hosts than entries, so evictions happen
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    logic                       op;
    logic [arpc_pkg::OPC_W-1:0] opcode;
    logic [arpc_pkg::MAC_W-1:0] smac;
    logic [arpc_pkg::IP_W-1:0]  sip;
    logic [arpc_pkg::IP_W-1:0]  tip;
    logic [arpc_pkg::IP_W-1:0]  qip;
  } arp_item_t;

  typedef struct packed {
    logic                       send_reply;
    logic [arpc_pkg::MAC_W-1:0] reply_mac;
    logic [arpc_pkg::IP_W-1:0]  reply_ip;
    logic                       found;
    logic [arpc_pkg::MAC_W-1:0] found_mac;
  } arp_result_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        cfg_valid_i  = 1'b0;
  logic                        cfg_ready_o;
  logic [arpc_pkg::CFG_IW-1:0] cfg_index_i  = '0;
  logic [arpc_pkg::MAC_W-1:0]  cfg_data_i   = '0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_ready_o;
  logic                        operation_i  = 1'b0;
  logic [arpc_pkg::OPC_W-1:0]  arp_opcode_i = '0;
  logic [arpc_pkg::MAC_W-1:0]  sender_mac_i = '0;
  logic [arpc_pkg::IP_W-1:0]   sender_ip_i  = '0;
  logic [arpc_pkg::IP_W-1:0]   target_ip_i  = '0;
  logic [arpc_pkg::IP_W-1:0]   query_ip_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i  = 1'b0;
  logic                        send_reply_o;
  logic [arpc_pkg::MAC_W-1:0]  reply_target_mac_o;
  logic [arpc_pkg::IP_W-1:0]   reply_target_ip_o;
  logic                        found_o;
  logic [arpc_pkg::MAC_W-1:0]  found_mac_o;

  arp_responder_with_cache #(
    .CACHE_DEPTH(CACHE_DEPTH),
    .HOST_BITS  (HOST_BITS)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .arp_opcode_i      (arp_opcode_i),
    .sender_mac_i      (sender_mac_i),
    .sender_ip_i       (sender_ip_i),
    .target_ip_i       (target_ip_i),
    .query_ip_i        (query_ip_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .send_reply_o      (send_reply_o),
    .reply_target_mac_o(reply_target_mac_o),
    .reply_target_ip_o (reply_target_ip_o),
    .found_o           (found_o),
    .found_mac_o       (found_mac_o)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench-side copy of the configuration and the cache
  // --------------------------------------------------------------------------
  logic [arpc_pkg::IP_W-1:0]  own_ip_reg   = '0;
  logic [arpc_pkg::MAC_W-1:0] own_mac_reg  = '0;
  logic [arpc_pkg::IP_W-1:0]  mask_reg     = arpc_pkg::NET_MASK_RST;
  logic [HOST_BITS-1:0]       cached_host [CACHE_DEPTH] = '{default: '0};
  logic [arpc_pkg::MAC_W-1:0] cached_mac  [CACHE_DEPTH] = '{default: '0};
  int                         insert_ptr   = 0;

  arp_result_t          expected_results[$];
  logic [HOST_BITS-1:0] host_pool [POOL_SIZE];
  int                   mismatch_count = 0;
  int                   tx_idle_pct    = 0;
  int                   rx_stall_pct   = 0;
  int                   rx_hold_cycles = 0;

  // Host part: the bits outside the mask, cut to the cache key width.
  function automatic logic [HOST_BITS-1:0] host_key(input logic [arpc_pkg::IP_W-1:0] ip);
    logic [arpc_pkg::IP_W-1:0] h;
    h = ip & ~mask_reg;
    return h[HOST_BITS-1:0];
  endfunction

  // Search from entry 0 upward; the first match wins, cleared entries included.
  function automatic int find_entry(input logic [HOST_BITS-1:0] key);
    for (int i = 0; i < CACHE_DEPTH; i++)
      if (cached_host[i] == key) return i;
    return -1;
  endfunction

  // Compute the result of one transaction and advance the cache copy.
  function automatic arp_result_t predict_arp(input arp_item_t it);
    arp_result_t          r;
    logic [HOST_BITS-1:0] key;
    int                   k;
    r = '0;
    if (it.op == arpc_pkg::OP_LOOKUP) begin
      k = find_entry(host_key(it.qip));
      if (k >= 0) begin
        r.found     = 1'b1;
        r.found_mac = cached_mac[k];
      end
    end else if (it.tip == own_ip_reg) begin
      if (it.opcode == arpc_pkg::ARP_OP_REQUEST) begin
        r.send_reply = 1'b1;
        r.reply_mac  = it.smac;
        r.reply_ip   = it.sip;
      end else if (it.opcode == arpc_pkg::ARP_OP_REPLY &&
                   (it.sip & mask_reg) == (own_ip_reg & mask_reg)) begin
        key = host_key(it.sip);
        k   = find_entry(key);
        if (k >= 0) begin
          cached_mac[k] = it.smac;
        end else begin
          // new host: overwrite the entry under the pointer, wrap after the last
          cached_host[insert_ptr] = key;
          cached_mac[insert_ptr]  = it.smac;
          insert_ptr = (insert_ptr == CACHE_DEPTH - 1) ? 0 : insert_ptr + 1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [arpc_pkg::MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[arpc_pkg::MAC_W-1:0];
  endfunction

  function automatic logic [HOST_BITS-1:0] pick_host();
    return host_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic arp_item_t make_header(input logic [arpc_pkg::OPC_W-1:0] opcode,
                                            input logic [arpc_pkg::MAC_W-1:0] smac,
                                            input logic [arpc_pkg::IP_W-1:0]  sip,
                                            input logic [arpc_pkg::IP_W-1:0]  tip);
    arp_item_t it;
    it        = '0;
    it.op     = arpc_pkg::OP_HEADER;
    it.opcode = opcode;
    it.smac   = smac;
    it.sip    = sip;
    it.tip    = tip;
    it.qip    = $urandom();
    return it;
  endfunction

  function automatic arp_item_t make_lookup(input logic [arpc_pkg::IP_W-1:0] qip);
    arp_item_t   it;
    logic [31:0] w;
    it        = '0;
    w         = $urandom();
    it.op     = arpc_pkg::OP_LOOKUP;
    it.opcode = w[arpc_pkg::OPC_W-1:0];
    it.smac   = rand_mac();
    it.sip    = $urandom();
    it.tip    = $urandom();
    it.qip    = qip;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: optional idle gap, then hold the transaction until accepted.
  // Valid stays high on return so a back-to-back transaction never drops it;
  // whoever goes on with something else lowers it.
  // --------------------------------------------------------------------------
  task automatic send_item(input arp_item_t it);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= it.op;
    arp_opcode_i <= it.opcode;
    sender_mac_i <= it.smac;
    sender_ip_i  <= it.sip;
    target_ip_i  <= it.tip;
    query_ip_i   <= it.qip;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(predict_arp(it));
  endtask

  // Stop offering and wait until every outstanding result has been taken.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Write all three registers while the block is idle.
  task automatic set_config(input logic [arpc_pkg::IP_W-1:0]  ip,
                            input logic [arpc_pkg::MAC_W-1:0] mac,
                            input logic [arpc_pkg::IP_W-1:0]  mask);
    logic [arpc_pkg::CFG_IW-1:0] reg_idx [3];
    logic [arpc_pkg::MAC_W-1:0]  reg_val [3];
    wait_for_results();
    reg_idx = '{arpc_pkg::CFG_OWN_IP, arpc_pkg::CFG_OWN_MAC, arpc_pkg::CFG_NET_MASK};
    reg_val = '{arpc_pkg::MAC_W'(ip), mac, arpc_pkg::MAC_W'(mask)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_idx[i];
      cfg_data_i  <= reg_val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (reg_idx[i])
        arpc_pkg::CFG_OWN_IP:   own_ip_reg  = reg_val[i][arpc_pkg::IP_W-1:0];
        arpc_pkg::CFG_OWN_MAC:  own_mac_reg = reg_val[i];
        arpc_pkg::CFG_NET_MASK: mask_reg    = reg_val[i][arpc_pkg::IP_W-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // --------------------------------------------------------------------------
  // Test: directed corner cases of the reply path and the cache
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    logic [arpc_pkg::IP_W-1:0] subnet;
    set_idling(0, 0);
    set_config(32'hC0A8_0A01, 48'h0200_0000_0001, arpc_pkg::NET_MASK_RST);
    subnet = own_ip_reg & mask_reg;
    // cleared entries: host 0 hits with MAC 0, any other host misses
    send_item(make_lookup(32'hFFFF_FF00));
    send_item(make_lookup(32'h0000_0037));
    // requests to us, with all-ones and all-zero sender fields
    send_item(make_header(arpc_pkg::ARP_OP_REQUEST, '1, '1, own_ip_reg));
    send_item(make_header(arpc_pkg::ARP_OP_REQUEST, '0, '0, own_ip_reg));
    // foreign target and unknown opcodes are dropped
    send_item(make_header(arpc_pkg::ARP_OP_REQUEST, rand_mac(), $urandom(),
                          own_ip_reg ^ 32'h1));
    send_item(make_header(16'h0000, rand_mac(), subnet | 32'h3, own_ip_reg));
    send_item(make_header(16'h0003, rand_mac(), subnet | 32'h3, own_ip_reg));
    send_item(make_header(16'hFFFF, rand_mac(), subnet | 32'h3, own_ip_reg));
    // insert a new host, then update it; lookup ignores the network part
    send_item(make_header(arpc_pkg::ARP_OP_REPLY, 48'h0A0B_0C0D_0E0F, subnet | 32'h05,
                          own_ip_reg));
    send_item(make_lookup(32'h0A00_0005));
    send_item(make_header(arpc_pkg::ARP_OP_REPLY, 48'h1122_3344_5566, subnet | 32'h05,
                          own_ip_reg));
    send_item(make_lookup(32'h0000_0005));
    // reply from host 0 lands on the first cleared entry
    send_item(make_header(arpc_pkg::ARP_OP_REPLY, 48'h7788_99AA_BBCC, subnet, own_ip_reg));
    send_item(make_lookup(32'h0000_0000));
    // reply from outside the subnet leaves the cache alone
    send_item(make_header(arpc_pkg::ARP_OP_REPLY, rand_mac(), own_ip_reg ^ 32'h0000_0100,
                          own_ip_reg));
    send_item(make_lookup(own_ip_reg));
    // highest host with all-ones MAC overwrites the entry under the pointer
    send_item(make_header(arpc_pkg::ARP_OP_REPLY, '1, subnet | 32'hFF, own_ip_reg));
    send_item(make_lookup('1));
    send_item(make_lookup(32'h0000_0000));
    // reply to a foreign target is dropped
    send_item(make_header(arpc_pkg::ARP_OP_REPLY, rand_mac(), subnet | 32'h09, ~own_ip_reg));
    send_item(make_lookup(32'h0000_0009));
  endtask

  // --------------------------------------------------------------------------
  // Test: long receiver hold-off fills the block and stalls its input,
  // then the sender pauses, and sends lookups to a receiver stalling half the time once the last result is out
  // --------------------------------------------------------------------------
  task automatic test_output_backpressure();
    logic [arpc_pkg::IP_W-1:0] subnet;
    set_idling(0, 0);
    subnet = own_ip_reg & mask_reg;
    rx_hold_cycles = 300;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0)
        send_item(make_header(arpc_pkg::ARP_OP_REQUEST, rand_mac(), $urandom(), own_ip_reg));
      else if (i % 3 == 1)
        send_item(make_header(arpc_pkg::ARP_OP_REPLY, rand_mac(), subnet | (8'h40 + i),
                              own_ip_reg));
      else
        send_item(make_lookup(subnet | (8'h40 + i - 1)));
    end
    wait_for_results();
    set_idling(0, 50);
    for (int i = 0; i < 8; i++)
      send_item(make_lookup(subnet | (8'h40 + i)));
  endtask

  // --------------------------------------------------------------------------
  // Test: random traffic, mostly well-formed replies, lookups and requests
  // over a small host pool, the rest odd opcodes, foreign targets and noise
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input int n_items);
    arp_item_t                 it;
    logic [arpc_pkg::IP_W-1:0] r;
    logic [arpc_pkg::IP_W-1:0] r2;
    int                        kind;
    host_pool[0] = '0;
    host_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      r            = $urandom();
      host_pool[i] = r[HOST_BITS-1:0];
    end
    repeat (n_items) begin
      kind = $urandom_range(99);
      r    = $urandom();
      r2   = $urandom();
      if (kind < 35) begin
        it = make_header(arpc_pkg::ARP_OP_REPLY, rand_mac(),
                         (own_ip_reg & mask_reg) |
                         ({r[arpc_pkg::IP_W-1:HOST_BITS], pick_host()} & ~mask_reg),
                         own_ip_reg);
      end else if (kind < 60) begin
        it = make_lookup({r[arpc_pkg::IP_W-1:HOST_BITS], pick_host()});
      end else if (kind < 75) begin
        it = make_header(arpc_pkg::ARP_OP_REQUEST, rand_mac(), r, own_ip_reg);
      end else if (kind < 83) begin
        // odd opcode aimed at us, small values half of the time
        it = make_header(r2[0] ? r2[31:16] : {12'h000, r2[3:0]}, rand_mac(), r,
                         own_ip_reg);
      end else if (kind < 91) begin
        it = make_header(r2[0] ? arpc_pkg::ARP_OP_REQUEST : arpc_pkg::ARP_OP_REPLY,
                         rand_mac(), r, own_ip_reg ^ (32'h1 << $urandom_range(31)));
      end else begin
        it        = make_header(r2[15:0], rand_mac(), r, r2[16] ? own_ip_reg : $urandom());
        it.op     = r2[17];
      end
      send_item(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a counted hold-off when one is requested
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    arp_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("%0t: result transaction with nothing outstanding", $time);
      end else begin
        want = expected_results.pop_front();
        check_field("send_reply",       64'(want.send_reply), 64'(send_reply_o));
        check_field("reply_target_mac", 64'(want.reply_mac),  64'(reply_target_mac_o));
        check_field("reply_target_ip",  64'(want.reply_ip),   64'(reply_target_ip_o));
        check_field("found",            64'(want.found),      64'(found_o));
        check_field("found_mac",        64'(want.found_mac),  64'(found_mac_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset once, then each test in turn across several settings
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_output_backpressure();

    // zero address, zero mask: every reply is in the subnet
    set_config('0, '0, '0);
    set_idling(0, 0);
    test_random_traffic(130);

    // all-ones address and MAC, 4-bit host part, bursty sender
    set_config('1, '1, 32'hFFFF_FFF0);
    set_idling(76, 0);
    test_random_traffic(130);

    // full mask: host part is always 0, slow receiver
    set_config($urandom(), rand_mac(), '1);
    set_idling(0, 76);
    test_random_traffic(130);

    // 16-bit host field, both sides idling
    set_config(32'h0A00_0001, rand_mac(), 32'hFFFF_0000);
    set_idling(25, 25);
    test_random_traffic(130);

    // back to the reset mask, no idling
    set_config(32'hC0A8_0A01, rand_mac(), arpc_pkg::NET_MASK_RST);
    set_idling(0, 0);
    test_random_traffic(130);

    wait_for_results();
    // catch any stray result after the last expected one
    repeat (CACHE_DEPTH + 8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/arpc_pkg.sv
sv/arpc_ram.sv
sv/arpc_datapath.sv
sv/arpc_ctrl.sv
sv/arp_responder_with_cache.sv
test/tb_arp_responder_with_cache.sv
